/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define FWU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define FWU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/fwu_pkg.sv */
// Shared types and constants of the FIFO with undo history.
package fwu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT   = 16;
   localparam int HISTORY_DEPTH_DEFAULT = 32;
   localparam int ID_WIDTH              = 8;
   localparam int REC_WIDTH             = ID_WIDTH + 1;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_UNDO    = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_NO_UNDO = 2'd3
   } status_type;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

endpackage

/* src/fifo_with_undo_history.sv */
// Top level: bounded FIFO of entry identifiers with an undo history stack.
// The block takes one command per cycle (enqueue, dequeue or undo) and gives one
// response per command in the cycle after acceptance, from an output register; it
// accepts a new command whenever that register is empty or being drained, so the
// sustained rate is one command per clock. Queue slots and history records live
// in two RAMs whose registered read ports always prefetch the slot at the queue
// head and the record on top of the history for the state the next command sees;
// a write to that slot in the same cycle is forwarded. A push onto a full history
// drops its oldest record. No clearing pass is needed after reset.
module fifo_with_undo_history #(
   parameter int QUEUE_DEPTH   = fwu_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int HISTORY_DEPTH = fwu_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_command,
   input  logic [fwu_pkg::ID_WIDTH-1:0]       req_entry_id,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [fwu_pkg::ID_WIDTH-1:0]       rsp_result_id,
   output logic                               rsp_undone_kind,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_queue_count
);

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int HAW = $clog2(HISTORY_DEPTH);
   localparam int HCW = $clog2(HISTORY_DEPTH + 1);
   localparam int IW  = fwu_pkg::ID_WIDTH;
   localparam int RW  = fwu_pkg::REC_WIDTH;

   logic [QAW-1:0] head_ff, head_in;
   logic [QCW-1:0] count_ff, count_in;
   logic [HAW-1:0] htop_ff, htop_in;
   logic [HCW-1:0] hcount_ff, hcount_in;

   logic           q_we;
   logic [QAW-1:0] q_waddr;
   logic [IW-1:0]  q_wdata;
   logic [QAW-1:0] q_raddr;
   logic [IW-1:0]  q_rdata;
   logic           q_byp_ff, q_byp_in;
   logic [IW-1:0]  q_byp_data_ff;
   logic [IW-1:0]  q_head_data;

   logic           h_we;
   logic [RW-1:0]  h_wdata;
   logic [HAW-1:0] h_raddr;
   logic [RW-1:0]  h_rdata;
   logic           h_byp_ff, h_byp_in;
   logic [RW-1:0]  h_byp_data_ff;
   logic [RW-1:0]  h_top_data;

   logic [QAW:0]   tail_sum;
   logic [QAW-1:0] tail;
   logic [QAW-1:0] head_inc, head_dec;
   logic [HAW-1:0] htop_inc, htop_dec;
   logic           accept;
   logic           push;
   logic           push_kind;
   logic [IW-1:0]  push_id;

   fwu_pkg::status_type status_in, status_ff;
   logic [IW-1:0]  result_in, result_ff;
   logic           kind_in, kind_ff;
   logic [QCW-1:0] out_count_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   assign tail_sum = (QAW+1)'(head_ff) + (QAW+1)'(count_ff);
   assign tail     = (tail_sum >= (QAW+1)'(QUEUE_DEPTH))
                     ? QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
   assign head_inc = (head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? QAW'(QUEUE_DEPTH - 1) : head_ff - 1'b1;
   assign htop_inc = (htop_ff == HAW'(HISTORY_DEPTH - 1)) ? '0 : htop_ff + 1'b1;
   assign htop_dec = (htop_ff == '0) ? HAW'(HISTORY_DEPTH - 1) : htop_ff - 1'b1;

   assign q_head_data = q_byp_ff ? q_byp_data_ff : q_rdata;
   assign h_top_data  = h_byp_ff ? h_byp_data_ff : h_rdata;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      htop_in   = htop_ff;
      hcount_in = hcount_ff;
      q_we      = 1'b0;
      q_waddr   = tail;
      q_wdata   = req_entry_id;
      push      = 1'b0;
      push_kind = fwu_pkg::KIND_ENQUEUE;
      push_id   = req_entry_id;
      status_in = fwu_pkg::STATUS_OK;
      result_in = '0;
      kind_in   = fwu_pkg::KIND_ENQUEUE;
      if (accept) begin
         case (req_command)
            fwu_pkg::CMD_ENQUEUE: begin
               if (count_ff == QCW'(QUEUE_DEPTH)) begin
                  status_in = fwu_pkg::STATUS_FULL;
               end else begin
                  q_we     = 1'b1;
                  count_in = count_ff + 1'b1;
                  push     = 1'b1;
               end
            end
            fwu_pkg::CMD_DEQUEUE: begin
               if (count_ff == '0) begin
                  status_in = fwu_pkg::STATUS_EMPTY;
               end else begin
                  result_in = q_head_data;
                  head_in   = head_inc;
                  count_in  = count_ff - 1'b1;
                  push      = 1'b1;
                  push_kind = fwu_pkg::KIND_DEQUEUE;
                  push_id   = q_head_data;
               end
            end
            fwu_pkg::CMD_UNDO: begin
               if (hcount_ff == '0) begin
                  status_in = fwu_pkg::STATUS_NO_UNDO;
               end else begin
                  htop_in   = htop_dec;
                  hcount_in = hcount_ff - 1'b1;
                  result_in = h_top_data[IW-1:0];
                  kind_in   = h_top_data[IW];
                  if (h_top_data[IW] == fwu_pkg::KIND_ENQUEUE) begin
                     if (count_ff == '0) begin
                        status_in = fwu_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     if (count_ff == QCW'(QUEUE_DEPTH)) begin
                        status_in = fwu_pkg::STATUS_FULL;
                     end else begin
                        head_in  = head_dec;
                        q_we     = 1'b1;
                        q_waddr  = head_dec;
                        q_wdata  = h_top_data[IW-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (push) begin
         htop_in = htop_inc;
         if (hcount_ff != HCW'(HISTORY_DEPTH)) begin
            hcount_in = hcount_ff + 1'b1;
         end
      end
   end

   assign h_we    = push;
   assign h_wdata = {push_kind, push_id};

   assign q_raddr  = head_in;
   assign h_raddr  = (htop_in == '0) ? HAW'(HISTORY_DEPTH - 1) : htop_in - 1'b1;
   assign q_byp_in = q_we && (q_waddr == q_raddr);
   assign h_byp_in = h_we && (htop_ff == h_raddr);

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         htop_ff      <= '0;
         hcount_ff    <= '0;
         q_byp_ff     <= 1'b0;
         h_byp_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         htop_ff      <= htop_in;
         hcount_ff    <= hcount_in;
         q_byp_ff     <= q_byp_in;
         h_byp_ff     <= h_byp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_byp_data_ff <= q_wdata;
      h_byp_data_ff <= h_wdata;
      if (accept) begin
         status_ff    <= status_in;
         result_ff    <= result_in;
         kind_ff      <= kind_in;
         out_count_ff <= count_in;
      end
   end

   fwu_ram #(
      .WIDTH (IW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   fwu_ram #(
      .WIDTH (RW),
      .DEPTH (HISTORY_DEPTH)
   ) u_history_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (htop_ff),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_id   = result_ff;
   assign rsp_undone_kind = kind_ff;
   assign rsp_queue_count = out_count_ff;

endmodule

/* src/fwu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read-first output.
module fwu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fwu_checker.sv */
// Port-level checker for the FIFO with undo history, bound to the top level.
`include "assert_macros.svh"

module fwu_checker #(
   parameter int QUEUE_DEPTH = fwu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_status,
   input logic [fwu_pkg::ID_WIDTH-1:0]       rsp_result_id,
   input logic                               rsp_undone_kind,
   input logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_queue_count
);

   `FWU_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "response valid after reset")

   `FWU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_status, rsp_result_id, rsp_undone_kind, rsp_queue_count}), "stalled response changed")

   `FWU_ASSERT(a_rsp_follows_req, clock, reset, req_valid && req_ready |=> rsp_valid, "accepted transaction gave no response")

   `FWU_ASSERT(a_no_extra_rsp, clock, reset, rsp_valid && rsp_ready && !(req_valid && req_ready) |=> !rsp_valid, "response repeated without a new transaction")

   `FWU_ASSERT(a_full_count, clock, reset, rsp_valid && (rsp_status == fwu_pkg::STATUS_FULL) |-> (rsp_queue_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)), "full status with queue not full")

endmodule

bind fifo_with_undo_history fwu_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fwu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_result_id   (rsp_result_id),
   .rsp_undone_kind (rsp_undone_kind),
   .rsp_queue_count (rsp_queue_count)
);

/* bench/testbench.sv */
// Self-checking testbench for the FIFO with undo history: directed table, random bursts.
`timescale 1ns / 1ps

module testbench;

   localparam int QDEPTH = fwu_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int HDEPTH = fwu_pkg::HISTORY_DEPTH_DEFAULT;
   localparam int IDW = fwu_pkg::ID_WIDTH;
   localparam int CW = $clog2(QDEPTH + 1);
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1250;
   localparam int LONG_HOLD = 90;
   localparam int HOLD_AFTER = 400;
   localparam int ROWS = 25;

   typedef struct packed {
      fwu_pkg::status_type status;
      logic [IDW-1:0] result_id;
      logic undone_kind;
      logic [CW-1:0] queue_count;
   } reply_type;

   typedef struct packed {
      logic [1:0] command;
      logic [IDW-1:0] entry_id;
      logic typed;
      reply_type reply;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = fwu_pkg::CMD_ENQUEUE;
   logic [IDW-1:0] req_entry_id = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [IDW-1:0] rsp_result_id;
   logic rsp_undone_kind;
   logic [CW-1:0] rsp_queue_count;

   logic [IDW-1:0] shadow_slot [QDEPTH];
   logic [fwu_pkg::REC_WIDTH-1:0] shadow_log [HDEPTH];
   int shadow_head = 0;
   int shadow_fill = 0;
   int shadow_log_top = 0;
   int shadow_log_fill = 0;

   reply_type pending_replies [$];
   int mismatch_count = 0;
   int replies_seen = 0;
   int status_tally [4] = '{0, 0, 0, 0};
   int dequeues_restored = 0;
   int random_items = 0;

   directed_row_type directed_rows [ROWS] = '{
      '{fwu_pkg::CMD_UNDO,    8'h00, 1'b1, '{fwu_pkg::STATUS_NO_UNDO, 8'h00, 1'b0, 5'd0}},
      '{fwu_pkg::CMD_DEQUEUE, 8'h00, 1'b1, '{fwu_pkg::STATUS_EMPTY,   8'h00, 1'b0, 5'd0}},
      '{CMD_UNUSED,           8'hFF, 1'b1, '{fwu_pkg::STATUS_OK,      8'h00, 1'b0, 5'd0}},
      '{fwu_pkg::CMD_ENQUEUE, 8'h00, 1'b1, '{fwu_pkg::STATUS_OK,      8'h00, 1'b0, 5'd1}},
      '{fwu_pkg::CMD_ENQUEUE, 8'hFF, 1'b1, '{fwu_pkg::STATUS_OK,      8'h00, 1'b0, 5'd2}},
      '{fwu_pkg::CMD_DEQUEUE, 8'hC3, 1'b1, '{fwu_pkg::STATUS_OK,      8'h00, 1'b0, 5'd1}},
      '{fwu_pkg::CMD_UNDO,    8'h5A, 1'b1, '{fwu_pkg::STATUS_OK,      8'h00, 1'b1, 5'd2}},
      '{fwu_pkg::CMD_UNDO,    8'h00, 1'b1, '{fwu_pkg::STATUS_OK,      8'hFF, 1'b0, 5'd1}},
      '{fwu_pkg::CMD_ENQUEUE, 8'h01, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h80, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h7F, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'hAA, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h55, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'hFE, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h02, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h04, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h08, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h10, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h20, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h40, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'hF0, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h0F, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'hC3, 1'b0, '0},
      '{fwu_pkg::CMD_ENQUEUE, 8'h3C, 1'b1, '{fwu_pkg::STATUS_FULL,    8'h00, 1'b0, 5'd16}},
      '{fwu_pkg::CMD_DEQUEUE, 8'h99, 1'b1, '{fwu_pkg::STATUS_OK,      8'h00, 1'b0, 5'd15}}
   };

   fifo_with_undo_history dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_entry_id(req_entry_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_result_id(rsp_result_id),
      .rsp_undone_kind(rsp_undone_kind),
      .rsp_queue_count(rsp_queue_count)
   );

   always #6 clock = ~clock;

   function automatic void log_operation(logic kind, logic [IDW-1:0] id);
      shadow_log[shadow_log_top] = {kind, id};
      shadow_log_top = (shadow_log_top + 1) % HDEPTH;
      if (shadow_log_fill < HDEPTH) shadow_log_fill++;
   endfunction

   function automatic reply_type predict_reply(logic [1:0] cmd, logic [IDW-1:0] id);
      reply_type r;
      logic [fwu_pkg::REC_WIDTH-1:0] rec;
      r.status = fwu_pkg::STATUS_OK;
      r.result_id = '0;
      r.undone_kind = fwu_pkg::KIND_ENQUEUE;
      case (cmd)
         fwu_pkg::CMD_ENQUEUE: begin
            if (shadow_fill == QDEPTH) begin
               r.status = fwu_pkg::STATUS_FULL;
            end else begin
               shadow_slot[(shadow_head + shadow_fill) % QDEPTH] = id;
               shadow_fill++;
               log_operation(fwu_pkg::KIND_ENQUEUE, id);
            end
         end
         fwu_pkg::CMD_DEQUEUE: begin
            if (shadow_fill == 0) begin
               r.status = fwu_pkg::STATUS_EMPTY;
            end else begin
               r.result_id = shadow_slot[shadow_head];
               shadow_head = (shadow_head + 1) % QDEPTH;
               shadow_fill--;
               log_operation(fwu_pkg::KIND_DEQUEUE, r.result_id);
            end
         end
         fwu_pkg::CMD_UNDO: begin
            if (shadow_log_fill == 0) begin
               r.status = fwu_pkg::STATUS_NO_UNDO;
            end else begin
               shadow_log_top = (shadow_log_top + HDEPTH - 1) % HDEPTH;
               shadow_log_fill--;
               rec = shadow_log[shadow_log_top];
               r.undone_kind = rec[IDW];
               r.result_id = rec[IDW-1:0];
               if (r.undone_kind == fwu_pkg::KIND_ENQUEUE) begin
                  if (shadow_fill == 0) r.status = fwu_pkg::STATUS_EMPTY;
                  else shadow_fill--;
               end else if (shadow_fill == QDEPTH) begin
                  r.status = fwu_pkg::STATUS_FULL;
               end else begin
                  shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
                  shadow_slot[shadow_head] = r.result_id;
                  shadow_fill++;
               end
            end
         end
         default: ;
      endcase
      r.queue_count = CW'(shadow_fill);
      return r;
   endfunction

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [1:0] pick_command(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         0: return roll < 85 ? fwu_pkg::CMD_ENQUEUE
                  : (roll < 97 ? fwu_pkg::CMD_DEQUEUE : fwu_pkg::CMD_UNDO);
         1: return roll < 85 ? fwu_pkg::CMD_DEQUEUE
                  : (roll < 97 ? fwu_pkg::CMD_ENQUEUE : fwu_pkg::CMD_UNDO);
         2: return roll < 88 ? fwu_pkg::CMD_UNDO
                  : (roll < 96 ? fwu_pkg::CMD_ENQUEUE : fwu_pkg::CMD_DEQUEUE);
         3: return roll < 4 ? CMD_UNUSED : 2'($urandom_range(0, 2));
         default: return 2'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic offer(input logic [1:0] cmd, input logic [IDW-1:0] id,
                        input bit idle_ok, input bit typed, input reply_type typed_reply);
      reply_type want;
      int gap;
      gap = idle_ok ? gap_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_id <= id;
      do @(posedge clock); while (!req_ready);
      want = predict_reply(cmd, id);
      pending_replies.push_back(typed ? typed_reply : want);
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         replies_seen++;
         status_tally[rsp_status]++;
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction status=%0d id=%0d kind=%0d count=%0d",
                     $time, rsp_status, rsp_result_id, rsp_undone_kind, rsp_queue_count);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status == fwu_pkg::STATUS_OK && rsp_undone_kind == fwu_pkg::KIND_DEQUEUE)
               dequeues_restored++;
            if (rsp_status !== want.status) begin
               mismatch_count++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
            end
            if (rsp_result_id !== want.result_id) begin
               mismatch_count++;
               $display("%0t: result_id expected %0d actual %0d",
                        $time, want.result_id, rsp_result_id);
            end
            if (rsp_undone_kind !== want.undone_kind) begin
               mismatch_count++;
               $display("%0t: undone_kind expected %0d actual %0d",
                        $time, want.undone_kind, rsp_undone_kind);
            end
            if (rsp_queue_count !== want.queue_count) begin
               mismatch_count++;
               $display("%0t: queue_count expected %0d actual %0d",
                        $time, want.queue_count, rsp_queue_count);
            end
         end
      end
   end

   initial begin
      int stall_left;
      int stall_free;
      bit held_long;
      stall_left = 0;
      stall_free = 0;
      held_long = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (!held_long && replies_seen >= HOLD_AFTER) begin
            // hold off long enough for the block to back up its input
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            held_long = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (stall_free > 0) stall_free--;
            else if ($urandom_range(0, 29) == 0) stall_free = $urandom_range(30, 100);
            else if ($urandom_range(0, 3) == 0) stall_left = gap_length();
         end
      end
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int mode;
      int burst;
      bit quiet;
      bit paused;
      logic [1:0] cmd;
      paused = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i].command, directed_rows[i].entry_id, 1'b1,
               directed_rows[i].typed, directed_rows[i].reply);

      // wrap the history, then unwind it past its oldest surviving record
      repeat (3) begin
         repeat (QDEPTH)
            offer(fwu_pkg::CMD_ENQUEUE, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
         repeat (QDEPTH)
            offer(fwu_pkg::CMD_DEQUEUE, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end
      repeat (HDEPTH + 4) offer(fwu_pkg::CMD_UNDO, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);

      while (random_items < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         mode = mode < 3 ? 0 : (mode < 5 ? 1 : (mode < 7 ? 2 : (mode < 9 ? 3 : 4)));
         burst = $urandom_range(3, 40);
         quiet = $urandom_range(0, 3) == 0;
         if (!paused && random_items >= RANDOM_ITEMS / 2) begin
            // drop valid and drain everything before going on
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_replies.size() != 0) @(posedge clock);
            paused = 1'b1;
         end
         repeat (burst) begin
            cmd = pick_command(mode);
            offer(cmd, 8'($urandom_range(0, 255)), !quiet, 1'b0, '0);
            if (cmd != CMD_UNUSED) random_items++;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d transactions (%0d directed, %0d dequeues restored by undo)",
               replies_seen, ROWS, dequeues_restored);
      $display("Status mix: ok %0d, empty %0d, full %0d, nothing to undo %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/fwu_pkg.sv
src/fwu_ram.sv
src/fifo_with_undo_history.sv
src/fwu_checker.sv
bench/testbench.sv
